// ===== rtl/eqrs_pkg.sv =====
// eqrs_pkg: types, codes and defaults for the equalizer chip read sequencer
// no dependencies; used by equalizer_chip_read_sequencer_core
package eqrs_pkg;

  localparam int unsigned WaitWidth   = 12;
  localparam int unsigned IndexWidth  = 5;
  localparam int unsigned SampleWidth = 16;
  localparam int unsigned CfgIdxWidth = 2;

  localparam int unsigned ReadsPerFrameDefault = 14;

  localparam logic [WaitWidth-1:0] ResetPulseDefault   = 12'd100;
  localparam logic [WaitWidth-1:0] SettleDefault       = 12'd36;
  localparam logic [WaitWidth-1:0] StrobePeriodDefault = 12'd72;

  // register indexes on the configuration port
  localparam logic [CfgIdxWidth-1:0] RegResetPulse   = 2'd0;
  localparam logic [CfgIdxWidth-1:0] RegSettle       = 2'd1;
  localparam logic [CfgIdxWidth-1:0] RegStrobePeriod = 2'd2;

  // command codes
  localparam logic [1:0] CmdStart    = 2'd0;
  localparam logic [1:0] CmdTick     = 2'd1;
  localparam logic [1:0] CmdConvDone = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_RESET_HIGH  = 3'd1,
    PH_STROBE_HIGH = 3'd2,
    PH_SETTLE      = 3'd3,
    PH_READ_LEFT   = 3'd4,
    PH_READ_RIGHT  = 3'd5
  } phase_t;

  typedef struct packed {
    logic [1:0]             command;
    logic [SampleWidth-1:0] adc_value;
  } in_item_t;

  typedef struct packed {
    logic                   eq_reset;
    logic                   eq_strobe;
    logic                   adc_start;
    logic                   adc_select;
    logic                   sample_valid;
    logic [SampleWidth-1:0] sample_value;
    logic [IndexWidth-1:0]  sample_index;
    logic                   frame_done;
  } out_item_t;

endpackage

// ===== rtl/equalizer_chip_read_sequencer_core.sv =====
// equalizer_chip_read_sequencer_core: top level of the equalizer read sequencer
// depends on eqrs_pkg for item types, command codes, phases and defaults

// Drives the reset and strobe lines of a seven-band equalizer chip and the
// start/select of a two-channel converter. Every input transaction (start,
// one-microsecond tick or conversion done) yields exactly one result
// transaction showing pin levels after the update, a one-transaction
// conversion start pulse, the selected channel and, on conversion done during
// a read, the sample with its frame position (frame_done on the last one).
// Timing: one transaction per clock sustained while out_stall is low; each
// result is registered. The state update is a single pass of small
// logic from the accepted item to the registered state and result. A two-entry
// output buffer (result register plus skid register) lets one more input be
// taken while a result is stalled; in_stall rises only when both are full.
// Configuration writes are always ready and must only be made while idle.
module equalizer_chip_read_sequencer_core #(
  parameter int unsigned READS_PER_FRAME = eqrs_pkg::ReadsPerFrameDefault
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  eqrs_pkg::in_item_t                   in_data,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output eqrs_pkg::out_item_t                  out_data,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [eqrs_pkg::CfgIdxWidth-1:0]     cfg_index,
  input  logic [eqrs_pkg::WaitWidth-1:0]       cfg_data
);

  localparam logic [eqrs_pkg::IndexWidth-1:0] LastIndex =
    eqrs_pkg::IndexWidth'(READS_PER_FRAME - 1);

  // configuration registers
  logic [eqrs_pkg::WaitWidth-1:0] reset_pulse_us;
  logic [eqrs_pkg::WaitWidth-1:0] settle_us;
  logic [eqrs_pkg::WaitWidth-1:0] strobe_period_us;

  // sequencer state
  eqrs_pkg::phase_t                phase, phase_next;
  logic [eqrs_pkg::WaitWidth-1:0]  wait_count, wait_count_next;
  logic                            timer_running, timer_running_next;
  logic [eqrs_pkg::IndexWidth-1:0] read_index, read_index_next;
  logic                            reset_level, reset_level_next;
  logic                            strobe_level, strobe_level_next;

  // result for the item at the input
  eqrs_pkg::out_item_t               result_next;
  logic                              result_next_start;
  logic                              result_next_valid;
  logic [eqrs_pkg::SampleWidth-1:0]  result_next_value;
  logic [eqrs_pkg::IndexWidth-1:0]   result_next_index;
  logic                              result_next_done;

  // output buffer
  eqrs_pkg::out_item_t result, skid;
  logic                skid_valid;

  logic in_accept;
  logic out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !skid_valid;
  // result register can take a new value this cycle
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      reset_pulse_us   <= eqrs_pkg::ResetPulseDefault;
      settle_us        <= eqrs_pkg::SettleDefault;
      strobe_period_us <= eqrs_pkg::StrobePeriodDefault;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        eqrs_pkg::RegResetPulse:   reset_pulse_us   <= cfg_data;
        eqrs_pkg::RegSettle:       settle_us        <= cfg_data;
        eqrs_pkg::RegStrobePeriod: strobe_period_us <= cfg_data;
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // next state and result for the item at the input
  always_comb begin
    phase_next         = phase;
    wait_count_next    = wait_count;
    timer_running_next = timer_running;
    read_index_next    = read_index;
    reset_level_next   = reset_level;
    strobe_level_next  = strobe_level;

    result_next_start  = 1'b0;
    result_next_valid  = 1'b0;
    result_next_value  = '0;
    result_next_index  = '0;
    result_next_done   = 1'b0;

    unique case (in_data.command)
      eqrs_pkg::CmdStart: begin
        // start restarts the frame even while busy
        phase_next         = eqrs_pkg::PH_RESET_HIGH;
        reset_level_next   = 1'b1;
        strobe_level_next  = 1'b0;
        read_index_next    = '0;
        wait_count_next    = reset_pulse_us;
        timer_running_next = 1'b1;
      end
      eqrs_pkg::CmdTick: begin
        if (timer_running) begin
          if (wait_count > eqrs_pkg::WaitWidth'(1)) begin
            wait_count_next = wait_count - eqrs_pkg::WaitWidth'(1);
          end else begin
            // a zero wait ends on the first tick, like a wait of one
            wait_count_next    = '0;
            timer_running_next = 1'b0;
            if (phase == eqrs_pkg::PH_RESET_HIGH || phase == eqrs_pkg::PH_STROBE_HIGH) begin
              reset_level_next   = 1'b0;
              strobe_level_next  = 1'b0;
              phase_next         = eqrs_pkg::PH_SETTLE;
              wait_count_next    = settle_us;
              timer_running_next = 1'b1;
            end else if (phase == eqrs_pkg::PH_SETTLE) begin
              phase_next        = eqrs_pkg::PH_READ_LEFT;
              result_next_start = 1'b1;
            end
          end
        end
      end
      eqrs_pkg::CmdConvDone: begin
        // conversion results outside a read are ignored
        if (phase == eqrs_pkg::PH_READ_LEFT || phase == eqrs_pkg::PH_READ_RIGHT) begin
          result_next_valid = 1'b1;
          result_next_value = in_data.adc_value;
          result_next_index = read_index;
          if (phase == eqrs_pkg::PH_READ_RIGHT) begin
            strobe_level_next = 1'b1;
          end
          if (read_index != LastIndex) begin
            read_index_next = read_index + eqrs_pkg::IndexWidth'(1);
            if (phase == eqrs_pkg::PH_READ_LEFT) begin
              phase_next        = eqrs_pkg::PH_READ_RIGHT;
              result_next_start = 1'b1;
            end else begin
              phase_next         = eqrs_pkg::PH_STROBE_HIGH;
              wait_count_next    = strobe_period_us;
              timer_running_next = 1'b1;
            end
          end else begin
            // last read of the frame, also on a left read for odd lengths
            read_index_next  = '0;
            result_next_done = 1'b1;
            phase_next       = eqrs_pkg::PH_IDLE;
          end
        end
      end
      default: ;  // unused command code
    endcase

    result_next.eq_reset     = reset_level_next;
    result_next.eq_strobe    = strobe_level_next;
    result_next.adc_start    = result_next_start;
    result_next.adc_select   = (phase_next == eqrs_pkg::PH_READ_RIGHT);
    result_next.sample_valid = result_next_valid;
    result_next.sample_value = result_next_value;
    result_next.sample_index = result_next_index;
    result_next.frame_done   = result_next_done;
  end

  // state register, updated on every accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= eqrs_pkg::PH_IDLE;
      wait_count    <= '0;
      timer_running <= 1'b0;
      read_index    <= '0;
      reset_level   <= 1'b0;
      strobe_level  <= 1'b0;
    end else if (in_accept) begin
      phase         <= phase_next;
      wait_count    <= wait_count_next;
      timer_running <= timer_running_next;
      read_index    <= read_index_next;
      reset_level   <= reset_level_next;
      strobe_level  <= strobe_level_next;
    end
  end

  // output buffer: result register with a skid register behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        result <= skid;
      end else if (in_accept) begin
        result <= result_next;
      end
    end else if (in_accept) begin
      skid <= result_next;
    end
  end

  assign out_data = result;

endmodule
